// ----- rtl/core/hlpb_pkg.sv -----
// shared types, constants and helper functions for the lod pyramid builder
// no dependencies; used by the controller, the datapath and the top level
package hlpb_pkg;

  // pyramid geometry
  localparam int LEVELS        = 4;
  localparam int MAX_WIDTH_LOG = 6;
  localparam int MAX_WIDTH     = 1 << MAX_WIDTH_LOG;

  // field widths
  localparam int CFG_W    = 7;
  localparam int HEIGHT_W = 16;
  localparam int ALPHA_W  = 8;
  localparam int PACKED_A = 4 * ALPHA_W;

  localparam logic [CFG_W-1:0] BASE_WIDTH_RESET = CFG_W'(64);

  // width of a level width value and of a build coordinate
  localparam int W_W     = MAX_WIDTH_LOG + 1;
  localparam int COORD_W = (MAX_WIDTH_LOG > 1) ? MAX_WIDTH_LOG : 1;
  localparam int LVL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  // levels are packed one after another, level l using a plane of side MAX_WIDTH >> l
  function automatic int total_depth();
    int acc;
    acc = 0;
    for (int i = 0; i < LEVELS; i++) begin
      acc = acc + (1 << (2 * (MAX_WIDTH_LOG - i)));
    end
    return acc;
  endfunction

  localparam int DEPTH  = total_depth();
  localparam int ADDR_W = $clog2(DEPTH);

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_BUILD = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  // start address of a level plane
  function automatic logic [ADDR_W-1:0] level_offset(input logic [LVL_W-1:0] lvl);
    int acc;
    acc = 0;
    for (int i = 0; i < LEVELS; i++) begin
      if (i < int'(lvl)) begin
        acc = acc + (1 << (2 * (MAX_WIDTH_LOG - i)));
      end
    end
    return ADDR_W'(acc);
  endfunction

  // side of a level: halve and round up once per level
  function automatic logic [W_W-1:0] level_width(input logic [W_W-1:0]   base,
                                                 input logic [LVL_W-1:0] lvl);
    logic [W_W:0] w;
    w = (W_W + 1)'(base);
    for (int i = 0; i < LEVELS - 1; i++) begin
      if (i < int'(lvl)) begin
        w = (w + 1'b1) >> 1;
      end
    end
    return W_W'(w);
  endfunction

  // controller to datapath
  typedef struct packed {
    logic take;
    logic exec;
    logic build_init;
    logic rd_parent;
    logic wr_build;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic op_build;
    logic build_none;
    logic last_rd;
    logic build_last;
  } sts_t;

endpackage

// ----- rtl/core/heightmap_lod_pyramid_builder_top.sv -----
// write, read and write-path timing: an item is taken, executed in the next cycle and its
// result registered in S_RESP once the result register is free; a new item is taken as that
// result is loaded, so no item is taken while another is in flight; out_valid_o is registered
// build: four parent reads through the single store read port, one wait and one write per
// interior sample, one read, one wait and one write per border sample, for levels 1 and up
// reset: controller idle, no result pending, base width 64; stores are undefined until written
module heightmap_lod_pyramid_builder_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // item input channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [1:0]                           opcode_i,
  input  logic [1:0]                           level_i,
  input  logic [5:0]                           col_i,
  input  logic [5:0]                           row_i,
  input  logic signed [hlpb_pkg::HEIGHT_W-1:0] height_in_i,
  input  logic [hlpb_pkg::ALPHA_W-1:0]         alpha_r_in_i,
  input  logic [hlpb_pkg::ALPHA_W-1:0]         alpha_g_in_i,
  input  logic [hlpb_pkg::ALPHA_W-1:0]         alpha_b_in_i,
  input  logic [hlpb_pkg::ALPHA_W-1:0]         alpha_a_in_i,
  // result channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [hlpb_pkg::HEIGHT_W-1:0] height_out_o,
  output logic [hlpb_pkg::ALPHA_W-1:0]         alpha_r_out_o,
  output logic [hlpb_pkg::ALPHA_W-1:0]         alpha_g_out_o,
  output logic [hlpb_pkg::ALPHA_W-1:0]         alpha_b_out_o,
  output logic [hlpb_pkg::ALPHA_W-1:0]         alpha_a_out_o,
  output logic                                 status_o,
  // base width register write
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [hlpb_pkg::CFG_W-1:0]           cfg_data_i
);

  hlpb_pkg::cmd_t cmd;
  hlpb_pkg::sts_t sts;
  logic           cfg_we;

  // register writes are always taken; the user must send them only while the block is idle, it does not enforce this
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // sequencing: item handshake, build walk and result register loading
  hlpb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // stores, address generation, 2x2 max and average, result payload
  hlpb_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we),
    .cfg_data_i    (cfg_data_i),
    .opcode_i      (opcode_i),
    .level_i       (level_i),
    .col_i         (col_i),
    .row_i         (row_i),
    .height_in_i   (height_in_i),
    .alpha_r_in_i  (alpha_r_in_i),
    .alpha_g_in_i  (alpha_g_in_i),
    .alpha_b_in_i  (alpha_b_in_i),
    .alpha_a_in_i  (alpha_a_in_i),
    .height_out_o  (height_out_o),
    .alpha_r_out_o (alpha_r_out_o),
    .alpha_g_out_o (alpha_g_out_o),
    .alpha_b_out_o (alpha_b_out_o),
    .alpha_a_out_o (alpha_a_out_o),
    .status_o      (status_o)
  );

  // a taken item is executed next cycle, so no second item may follow at once
  a_take_then_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.take |=> in_stall_o)
    else $error("item taken in the cycle after another item");

  // a result is never loaded over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!out_valid_o || !out_stall_i))
    else $error("result register overwritten while stalled");

  // no item is taken while the build walk reads the stores
  a_build_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.rd_parent || cmd.wr_build) |-> in_stall_o)
    else $error("item taken during a build");

endmodule

// ----- rtl/core/hlpb_ram.sv -----
// generic single-write, single-read memory with registered read data
// no dependencies
module hlpb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/core/hlpb_ctrl.sv -----
// controller state machine for the lod pyramid builder
// depends on hlpb_pkg (cmd_t, sts_t)
module hlpb_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  hlpb_pkg::sts_t sts_i,
  output hlpb_pkg::cmd_t cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_BRD  = 6'b000100,
    S_BWT  = 6'b001000,
    S_BWR  = 6'b010000,
    S_RESP = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   in_ready;

  assign out_free = !out_valid_q || !out_stall_i;
  assign in_ready = (state_q == S_IDLE) || ((state_q == S_RESP) && out_free);
  assign in_stall_o = !in_ready;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.take = in_valid_i && in_ready;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        if (sts_i.op_build && !sts_i.build_none) begin
          cmd_o.build_init = 1'b1;
          state_d          = S_BRD;
        end else begin
          state_d = S_RESP;
        end
      end
      S_BRD: begin
        cmd_o.rd_parent = 1'b1;
        if (sts_i.last_rd) begin
          state_d = S_BWT;
        end
      end
      S_BWT: begin
        state_d = S_BWR;
      end
      S_BWR: begin
        cmd_o.wr_build = 1'b1;
        state_d = sts_i.build_last ? S_RESP : S_BRD;
      end
      S_RESP: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = in_valid_i ? S_EXEC : S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/core/hlpb_dpath.sv -----
// datapath: item and config registers, address generation, sample stores,
// 2x2 reduction and result register; depends on hlpb_pkg and hlpb_ram
module hlpb_dpath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  hlpb_pkg::cmd_t                       cmd_i,
  output hlpb_pkg::sts_t                       sts_o,
  input  logic                                 cfg_we_i,
  input  logic [hlpb_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic [1:0]                           opcode_i,
  input  logic [1:0]                           level_i,
  input  logic [5:0]                           col_i,
  input  logic [5:0]                           row_i,
  input  logic signed [hlpb_pkg::HEIGHT_W-1:0] height_in_i,
  input  logic [hlpb_pkg::ALPHA_W-1:0]         alpha_r_in_i,
  input  logic [hlpb_pkg::ALPHA_W-1:0]         alpha_g_in_i,
  input  logic [hlpb_pkg::ALPHA_W-1:0]         alpha_b_in_i,
  input  logic [hlpb_pkg::ALPHA_W-1:0]         alpha_a_in_i,
  output logic signed [hlpb_pkg::HEIGHT_W-1:0] height_out_o,
  output logic [hlpb_pkg::ALPHA_W-1:0]         alpha_r_out_o,
  output logic [hlpb_pkg::ALPHA_W-1:0]         alpha_g_out_o,
  output logic [hlpb_pkg::ALPHA_W-1:0]         alpha_b_out_o,
  output logic [hlpb_pkg::ALPHA_W-1:0]         alpha_a_out_o,
  output logic                                 status_o
);

  localparam int AW = hlpb_pkg::ADDR_W;
  localparam int HW = hlpb_pkg::HEIGHT_W;
  localparam int PW = hlpb_pkg::PACKED_A;
  localparam int SW = hlpb_pkg::ALPHA_W + 2;

  // item register
  hlpb_pkg::op_e                     op_q;
  logic [1:0]                        lvl_in_q;
  logic [5:0]                        col_q, row_q;
  logic [HW-1:0]                     h_in_q;
  logic [PW-1:0]                     a_in_q;
  logic [hlpb_pkg::CFG_W-1:0]        base_q;

  // build counters
  logic [hlpb_pkg::LVL_W-1:0]        blvl_q;
  logic [hlpb_pkg::COORD_W-1:0]      x_q, y_q;
  logic [1:0]                        k_q;

  // reduction
  logic                              acc_en_q, acc_first_q;
  logic signed [HW-1:0]              acc_h_q;
  logic [3:0][SW-1:0]                sum_q;

  // result
  logic                              res_bad_q, res_rd_q;
  logic signed [HW-1:0]              out_h_q;
  logic [PW-1:0]                     out_a_q;
  logic                              out_st_q;

  logic [hlpb_pkg::W_W-1:0]          eff_base, w_host, wc;
  logic [hlpb_pkg::LVL_W-1:0]        host_l, plvl;
  logic [hlpb_pkg::COORD_W-1:0]      wc_m1;
  logic                              lvl_ok, wr_ok, rd_ok, is_build, bad;
  logic                              on_border;
  logic [AW-1:0]                     host_addr, par_addr, dst_addr;
  logic                              ram_we, ram_re;
  logic [AW-1:0]                     ram_waddr, ram_raddr;
  logic [HW-1:0]                     ram_wh, rd_h;
  logic [PW-1:0]                     ram_wa, rd_a, build_a;

  // saturate base width into the supported range
  always_comb begin
    if (int'(base_q) < 2) begin
      eff_base = hlpb_pkg::W_W'(2);
    end else if (int'(base_q) > hlpb_pkg::MAX_WIDTH) begin
      eff_base = hlpb_pkg::W_W'(hlpb_pkg::MAX_WIDTH);
    end else begin
      eff_base = hlpb_pkg::W_W'(base_q);
    end
  end

  // host request checks
  assign lvl_ok = int'(lvl_in_q) < hlpb_pkg::LEVELS;
  assign host_l = hlpb_pkg::LVL_W'(lvl_in_q);
  assign w_host = hlpb_pkg::level_width(eff_base, host_l);

  always_comb begin
    wr_ok    = 1'b0;
    rd_ok    = 1'b0;
    is_build = 1'b0;
    unique case (op_q)
      hlpb_pkg::OP_WRITE: begin
        wr_ok = (lvl_in_q == 2'd0) && (int'(col_q) < int'(eff_base))
                && (int'(row_q) < int'(eff_base));
      end
      hlpb_pkg::OP_BUILD: begin
        is_build = 1'b1;
      end
      hlpb_pkg::OP_READ: begin
        rd_ok = lvl_ok && (int'(col_q) < int'(w_host)) && (int'(row_q) < int'(w_host));
      end
      default: begin
        wr_ok = 1'b0;
      end
    endcase
  end

  assign bad = !(wr_ok || rd_ok || is_build);

  assign host_addr = hlpb_pkg::level_offset(host_l)
                   + (AW'(row_q) << (hlpb_pkg::MAX_WIDTH_LOG - int'(host_l)))
                   + AW'(col_q);

  // build addressing
  assign wc        = hlpb_pkg::level_width(eff_base, blvl_q);
  assign wc_m1     = hlpb_pkg::COORD_W'(wc - 1'b1);
  assign on_border = (x_q == '0) || (y_q == '0) || (x_q == wc_m1) || (y_q == wc_m1);
  assign plvl      = hlpb_pkg::LVL_W'(blvl_q - 1'b1);

  // parent sample k: row 2y + k[1], column 2x + k[0]
  assign par_addr = hlpb_pkg::level_offset(plvl)
                  + (AW'({y_q, k_q[1]}) << (hlpb_pkg::MAX_WIDTH_LOG - int'(plvl)))
                  + AW'({x_q, k_q[0]});
  assign dst_addr = hlpb_pkg::level_offset(blvl_q)
                  + (AW'(y_q) << (hlpb_pkg::MAX_WIDTH_LOG - int'(blvl_q)))
                  + AW'(x_q);

  // border samples copy, interior samples average (truncating)
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      build_a[i*8 +: 8] = on_border ? sum_q[i][7:0] : sum_q[i][SW-1:2];
    end
  end

  assign ram_we    = (cmd_i.exec && wr_ok) || cmd_i.wr_build;
  assign ram_waddr = cmd_i.wr_build ? dst_addr : host_addr;
  assign ram_wh    = cmd_i.wr_build ? acc_h_q : h_in_q;
  assign ram_wa    = cmd_i.wr_build ? build_a : a_in_q;
  assign ram_re    = (cmd_i.exec && rd_ok) || cmd_i.rd_parent;
  assign ram_raddr = cmd_i.rd_parent ? par_addr : host_addr;

  hlpb_ram #(
    .WIDTH (HW),
    .DEPTH (hlpb_pkg::DEPTH)
  ) u_height_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (ram_wh),
    .rd_en_i   (ram_re),
    .rd_addr_i (ram_raddr),
    .rd_data_o (rd_h)
  );

  hlpb_ram #(
    .WIDTH (PW),
    .DEPTH (hlpb_pkg::DEPTH)
  ) u_alpha_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (ram_wa),
    .rd_en_i   (ram_re),
    .rd_addr_i (ram_raddr),
    .rd_data_o (rd_a)
  );

  // status to controller
  assign sts_o.op_build   = is_build;
  assign sts_o.build_none = (hlpb_pkg::LEVELS == 1);
  assign sts_o.last_rd    = on_border ? (k_q == 2'd0) : (&k_q);
  assign sts_o.build_last = (int'(blvl_q) == hlpb_pkg::LEVELS - 1)
                            && (x_q == wc_m1) && (y_q == wc_m1);

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      op_q     <= hlpb_pkg::op_e'(opcode_i);
      lvl_in_q <= level_i;
      col_q    <= col_i;
      row_q    <= row_i;
      h_in_q   <= height_in_i;
      a_in_q   <= {alpha_a_in_i, alpha_b_in_i, alpha_g_in_i, alpha_r_in_i};
    end
    if (acc_en_q) begin
      if (acc_first_q || ($signed(rd_h) > acc_h_q)) begin
        acc_h_q <= $signed(rd_h);
      end
      for (int i = 0; i < 4; i++) begin
        sum_q[i] <= (acc_first_q ? SW'(0) : sum_q[i]) + SW'(rd_a[i*8 +: 8]);
      end
    end
    if (cmd_i.exec) begin
      res_bad_q <= bad;
      res_rd_q  <= rd_ok;
    end
    if (cmd_i.load_out) begin
      out_h_q  <= res_rd_q ? $signed(rd_h) : '0;
      out_a_q  <= res_rd_q ? rd_a : '0;
      out_st_q <= res_bad_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= hlpb_pkg::BASE_WIDTH_RESET;
      blvl_q      <= '0;
      x_q         <= '0;
      y_q         <= '0;
      k_q         <= '0;
      acc_en_q    <= 1'b0;
      acc_first_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        base_q <= cfg_data_i;
      end
      acc_en_q    <= cmd_i.rd_parent;
      acc_first_q <= (k_q == 2'd0);
      if (cmd_i.build_init) begin
        blvl_q <= hlpb_pkg::LVL_W'(1);
        x_q    <= '0;
        y_q    <= '0;
        k_q    <= '0;
      end else begin
        if (cmd_i.rd_parent) begin
          k_q <= sts_o.last_rd ? 2'd0 : k_q + 2'd1;
        end
        if (cmd_i.wr_build) begin
          if (x_q == wc_m1) begin
            x_q <= '0;
            if (y_q == wc_m1) begin
              y_q    <= '0;
              blvl_q <= blvl_q + 1'b1;
            end else begin
              y_q <= y_q + 1'b1;
            end
          end else begin
            x_q <= x_q + 1'b1;
          end
        end
      end
    end
  end

  assign height_out_o  = out_h_q;
  assign alpha_r_out_o = out_a_q[7:0];
  assign alpha_g_out_o = out_a_q[15:8];
  assign alpha_b_out_o = out_a_q[23:16];
  assign alpha_a_out_o = out_a_q[31:24];
  assign status_o      = out_st_q;

endmodule
